@@ rtl/core/bole_pkg.sv @@
package bole_pkg;

    // default list capacity
    localparam int unsigned DEPTH_DEFAULT = 16;

    // cell position field, enough for the largest capacity (128 entries)
    localparam int unsigned IDX_W = 7;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned STAT_W  = 2;

    // request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 4'd0,
        CMD_INS_HEAD  = 4'd1,
        CMD_INS_AT    = 4'd2,
        CMD_DEL_TAIL  = 4'd3,
        CMD_DEL_HEAD  = 4'd4,
        CMD_DEL_AT    = 4'd5,
        CMD_SEARCH    = 4'd6,
        CMD_STATS     = 4'd7,
        CMD_DUMP      = 4'd8
    } cmd_t;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    pos;
        logic [IDX_W-1:0]    tail;
        logic [DATA_W-1:0]   data;
    } cell_ctl_t;

    // control sequencer states
    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_SCAN = 1'b1
    } fsm_state_t;

endpackage

@@ rtl/core/bole_cell.sv @@
module bole_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                             clk,
    input  bole_pkg::cell_ctl_t              ctl,
    input  logic [bole_pkg::DATA_W-1:0]      left,
    input  logic [bole_pkg::DATA_W-1:0]      right,
    input  logic [bole_pkg::DATA_W-1:0]      head,
    output logic [bole_pkg::DATA_W-1:0]      q
);

    localparam logic [bole_pkg::IDX_W-1:0] ME = bole_pkg::IDX_W'(INDEX);

    logic [bole_pkg::DATA_W-1:0] q_reg;
    logic [bole_pkg::DATA_W-1:0] q_next;

    // pick the new contents from the neighbors, the head cell or the request data
    always_comb
    begin
        q_next = q_reg;
        unique case (ctl.op)
            bole_pkg::CELL_HOLD:
            begin
                q_next = q_reg;
            end
            bole_pkg::CELL_INSERT:
            begin
                if (ME > ctl.pos)
                begin
                    q_next = left;
                end
                else if (ME == ctl.pos)
                begin
                    q_next = ctl.data;
                end
            end
            bole_pkg::CELL_REMOVE:
            begin
                if (ME >= ctl.pos && ME < ctl.tail)
                begin
                    q_next = right;
                end
            end
            bole_pkg::CELL_ROTATE:
            begin
                if (ME < ctl.tail)
                begin
                    q_next = right;
                end
                else if (ME == ctl.tail)
                begin
                    q_next = head;
                end
            end
        endcase
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ rtl/core/bounded_ordered_list_engine.sv @@
// Ordered list of up to DEPTH signed 32-bit values, head at position 1.
// Request channel: req_valid/req_stall with cmd, value, position; a request
// is taken at a clock edge where req_valid is high and req_stall is low.
// Result channel: rsp_valid/rsp_stall with status, found, element, count,
// minimum, maximum, last; a result is taken when rsp_valid is high and
// rsp_stall is low. last marks the final result of a request.
// The entries sit in a chain of cells that all shift together. Edits
// (append, inserts, deletes) and error or unknown requests give their single
// result in the cycle after the request and free the input again at once, so
// they run at one request per cycle while results are drained.
// Search, stats and dump of a non-empty list rotate the chain through cell 0,
// one element per cycle while the result can move. A dump gives
// one result per element, head first; search and stats give one result at
// the end of the pass, after which the list is back in its original order.
// When the receiver stalls, the result register holds, the rotation pauses
// and req_stall stays high until the result can move.
// Reset empties the list; entry contents are not cleared.
module bounded_ordered_list_engine #(
    parameter int unsigned DEPTH = bole_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [bole_pkg::CMD_W-1:0]           cmd,
    input  logic signed [bole_pkg::DATA_W-1:0]   value,
    input  logic [bole_pkg::POS_W-1:0]           position,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic [bole_pkg::STAT_W-1:0]          status,
    output logic                                 found,
    output logic signed [bole_pkg::DATA_W-1:0]   element,
    output logic [bole_pkg::COUNT_W-1:0]         count,
    output logic signed [bole_pkg::DATA_W-1:0]   minimum,
    output logic signed [bole_pkg::DATA_W-1:0]   maximum,
    output logic                                 last
);

    localparam int unsigned LEN_W = $clog2(DEPTH + 1);
    localparam int unsigned CNT_W = $clog2(DEPTH);
    localparam int unsigned DW    = bole_pkg::DATA_W;
    localparam int unsigned IW    = bole_pkg::IDX_W;

    // cell chain
    bole_pkg::cell_ctl_t cell_ctl;
    logic [DW-1:0]       cell_q [DEPTH];
    logic signed [DW-1:0] head;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DW-1:0] left_w;
            logic [DW-1:0] right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_inner_l
                assign left_w = cell_q[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_end
                assign right_w = '0;
            end
            else
            begin : g_inner_r
                assign right_w = cell_q[gi+1];
            end
            bole_cell #(
                .INDEX (gi)
            ) u_cell (
                .clk   (clk),
                .ctl   (cell_ctl),
                .left  (left_w),
                .right (right_w),
                .head  (cell_q[0]),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    assign head = cell_q[0];

    // control and result registers
    bole_pkg::fsm_state_t           state_reg, state_next;
    logic [LEN_W-1:0]               len_reg, len_next;
    logic [CNT_W-1:0]               scan_cnt_reg, scan_cnt_next;
    bole_pkg::cmd_t                 scan_cmd_reg, scan_cmd_next;
    logic signed [DW-1:0]           key_reg, key_next;
    logic                           found_acc_reg, found_acc_next;
    logic signed [DW-1:0]           min_acc_reg, min_acc_next;
    logic signed [DW-1:0]           max_acc_reg, max_acc_next;

    logic                           rsp_valid_reg, rsp_valid_next;
    logic [bole_pkg::STAT_W-1:0]    status_reg, status_next;
    logic                           found_reg, found_next;
    logic signed [DW-1:0]           element_reg, element_next;
    logic [bole_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic signed [DW-1:0]           minimum_reg, minimum_next;
    logic signed [DW-1:0]           maximum_reg, maximum_next;
    logic                           last_reg, last_next;

    logic                           take;
    logic                           out_free;
    logic                           full;
    logic                           empty;
    logic [bole_pkg::POS_W-1:0]     len_ext;
    logic                           pos_bad;
    logic [IW-1:0]                  tail_idx;
    logic [IW-1:0]                  pos_idx;
    logic                           scan_end;
    logic                           found_step;
    logic signed [DW-1:0]           min_step;
    logic signed [DW-1:0]           max_step;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != bole_pkg::FSM_IDLE) || !out_free;
    assign take      = req_valid && !req_stall;

    assign full     = (len_reg == LEN_W'(DEPTH));
    assign empty    = (len_reg == '0);
    assign len_ext  = bole_pkg::POS_W'(len_reg);
    assign pos_bad  = (position == '0) || (position > len_ext);
    assign tail_idx = IW'(len_reg - LEN_W'(1));
    assign pos_idx  = IW'(position - bole_pkg::POS_W'(1));
    assign scan_end = (IW'(scan_cnt_reg) == tail_idx);

    // running search hit and min/max including the current head
    always_comb
    begin
        found_step = found_acc_reg || (head == key_reg);
        min_step   = min_acc_reg;
        max_step   = max_acc_reg;
        if (scan_cnt_reg == '0 || head < min_acc_reg)
        begin
            min_step = head;
        end
        if (scan_cnt_reg == '0 || head > max_acc_reg)
        begin
            max_step = head;
        end
    end

    // sequencer: next state, cell control and result
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        scan_cnt_next  = scan_cnt_reg;
        scan_cmd_next  = scan_cmd_reg;
        key_next       = key_reg;
        found_acc_next = found_acc_reg;
        min_acc_next   = min_acc_reg;
        max_acc_next   = max_acc_reg;

        cell_ctl.op    = bole_pkg::CELL_HOLD;
        cell_ctl.pos   = '0;
        cell_ctl.tail  = tail_idx;
        cell_ctl.data  = value;

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        found_next     = found_reg;
        element_next   = element_reg;
        count_next     = count_reg;
        minimum_next   = minimum_reg;
        maximum_next   = maximum_reg;
        last_next      = last_reg;

        unique case (state_reg)
            bole_pkg::FSM_IDLE:
            begin
                if (take)
                begin
                    // one-shot result by default
                    rsp_valid_next = 1'b1;
                    status_next    = bole_pkg::STAT_OK;
                    found_next     = 1'b0;
                    element_next   = '0;
                    minimum_next   = '0;
                    maximum_next   = '0;
                    last_next      = 1'b1;
                    unique case (cmd)
                        bole_pkg::CMD_APPEND,
                        bole_pkg::CMD_INS_HEAD,
                        bole_pkg::CMD_INS_AT:
                        begin
                            if (full)
                            begin
                                status_next = bole_pkg::STAT_FULL;
                            end
                            else if (cmd == bole_pkg::CMD_INS_AT && position != 8'd1
                                     && pos_bad)
                            begin
                                status_next = bole_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                cell_ctl.op = bole_pkg::CELL_INSERT;
                                if (cmd == bole_pkg::CMD_APPEND)
                                begin
                                    cell_ctl.pos = IW'(len_reg);
                                end
                                else if (cmd == bole_pkg::CMD_INS_HEAD)
                                begin
                                    cell_ctl.pos = '0;
                                end
                                else
                                begin
                                    cell_ctl.pos = pos_idx;
                                end
                                len_next = len_reg + LEN_W'(1);
                            end
                        end
                        bole_pkg::CMD_DEL_TAIL,
                        bole_pkg::CMD_DEL_HEAD,
                        bole_pkg::CMD_DEL_AT:
                        begin
                            if (empty)
                            begin
                                status_next = bole_pkg::STAT_EMPTY;
                            end
                            else if (cmd == bole_pkg::CMD_DEL_AT && pos_bad)
                            begin
                                status_next = bole_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                cell_ctl.op = bole_pkg::CELL_REMOVE;
                                if (cmd == bole_pkg::CMD_DEL_TAIL)
                                begin
                                    cell_ctl.pos = tail_idx;
                                end
                                else if (cmd == bole_pkg::CMD_DEL_HEAD)
                                begin
                                    cell_ctl.pos = '0;
                                end
                                else
                                begin
                                    cell_ctl.pos = pos_idx;
                                end
                                len_next = len_reg - LEN_W'(1);
                            end
                        end
                        bole_pkg::CMD_SEARCH,
                        bole_pkg::CMD_STATS,
                        bole_pkg::CMD_DUMP:
                        begin
                            if (empty)
                            begin
                                status_next = bole_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // start a rotation pass, no result yet
                                rsp_valid_next = 1'b0;
                                state_next     = bole_pkg::FSM_SCAN;
                                scan_cnt_next  = '0;
                                scan_cmd_next  = bole_pkg::cmd_t'(cmd);
                                key_next       = value;
                                found_acc_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            status_next = bole_pkg::STAT_OK;
                        end
                    endcase
                    count_next = bole_pkg::COUNT_W'(len_next);
                end
            end
            bole_pkg::FSM_SCAN:
            begin
                if (out_free)
                begin
                    // move the next element into cell 0
                    cell_ctl.op    = bole_pkg::CELL_ROTATE;
                    found_acc_next = found_step;
                    min_acc_next   = min_step;
                    max_acc_next   = max_step;
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);

                    status_next    = bole_pkg::STAT_OK;
                    found_next     = 1'b0;
                    element_next   = '0;
                    count_next     = bole_pkg::COUNT_W'(len_reg);
                    minimum_next   = '0;
                    maximum_next   = '0;
                    last_next      = scan_end;

                    if (scan_cmd_reg == bole_pkg::CMD_DUMP)
                    begin
                        rsp_valid_next = 1'b1;
                        element_next   = head;
                    end
                    else if (scan_end)
                    begin
                        rsp_valid_next = 1'b1;
                        if (scan_cmd_reg == bole_pkg::CMD_SEARCH)
                        begin
                            found_next = found_step;
                        end
                        else
                        begin
                            minimum_next = min_step;
                            maximum_next = max_step;
                        end
                    end

                    if (scan_end)
                    begin
                        state_next = bole_pkg::FSM_IDLE;
                    end
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bole_pkg::FSM_IDLE;
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // scan and result payload
    always_ff @(posedge clk)
    begin
        scan_cnt_reg  <= scan_cnt_next;
        scan_cmd_reg  <= scan_cmd_next;
        key_reg       <= key_next;
        found_acc_reg <= found_acc_next;
        min_acc_reg   <= min_acc_next;
        max_acc_reg   <= max_acc_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        element_reg   <= element_next;
        count_reg     <= count_next;
        minimum_reg   <= minimum_next;
        maximum_reg   <= maximum_next;
        last_reg      <= last_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign element   = element_reg;
    assign count     = count_reg;
    assign minimum   = minimum_reg;
    assign maximum   = maximum_reg;
    assign last      = last_reg;

    // list never grows past capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(DEPTH))
        else $error("list length exceeds capacity");

    // length moves only on an accepted request
    a_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(len_reg))
        else $error("length changed without a request");

    // a rotation pass keeps the input closed and stays inside the list
    a_scan_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bole_pkg::FSM_SCAN) |-> (req_stall && !empty
            && IW'(scan_cnt_reg) <= tail_idx))
        else $error("scan ran past the tail or input open");

    // a result dropped from the register was taken by the receiver
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> (rsp_valid_reg && $stable(element_reg)
            && $stable(last_reg)))
        else $error("stalled result lost");

endmodule

@@ tb/sv/bole_list_checker.sv @@
`timescale 1ns / 100ps

module bole_list_checker #(
    parameter int unsigned DEPTH = bole_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_stall,
    input  logic [bole_pkg::CMD_W-1:0]          cmd,
    input  logic signed [bole_pkg::DATA_W-1:0]  value,
    input  logic [bole_pkg::POS_W-1:0]          position,
    input  logic                                rsp_valid,
    input  logic                                rsp_stall,
    input  logic [bole_pkg::STAT_W-1:0]         status,
    input  logic                                found,
    input  logic signed [bole_pkg::DATA_W-1:0]  element,
    input  logic [bole_pkg::COUNT_W-1:0]        count,
    input  logic signed [bole_pkg::DATA_W-1:0]  minimum,
    input  logic signed [bole_pkg::DATA_W-1:0]  maximum,
    input  logic                                last,
    output int                                  fail_count,
    output int                                  pending
);

    typedef struct packed {
        logic [bole_pkg::STAT_W-1:0]  status;
        logic                         found;
        logic [bole_pkg::DATA_W-1:0]  element;
        logic [bole_pkg::COUNT_W-1:0] count;
        logic [bole_pkg::DATA_W-1:0]  minimum;
        logic [bole_pkg::DATA_W-1:0]  maximum;
        logic                         last;
    } list_result_t;

    // predicted list contents, head at index 0
    logic signed [bole_pkg::DATA_W-1:0] list_cells [DEPTH];
    int unsigned                        list_len;
    list_result_t                       awaited_results [$];

    // queue one predicted result, count taken after the edit
    task automatic push_result(input logic [bole_pkg::STAT_W-1:0] st, input logic hit,
                               input logic [bole_pkg::DATA_W-1:0] elem,
                               input logic [bole_pkg::DATA_W-1:0] lo,
                               input logic [bole_pkg::DATA_W-1:0] hi, input logic fin);
        list_result_t r;
        r.status  = st;
        r.found   = hit;
        r.element = elem;
        r.count   = list_len[bole_pkg::COUNT_W-1:0];
        r.minimum = lo;
        r.maximum = hi;
        r.last    = fin;
        awaited_results.push_back(r);
    endtask

    // open a slot at idx and place v there
    task automatic shift_in(input int unsigned idx,
                            input logic signed [bole_pkg::DATA_W-1:0] v);
        for (int unsigned k = list_len; k > idx; k--)
            list_cells[k] = list_cells[k-1];
        list_cells[idx] = v;
        list_len++;
    endtask

    // close the slot at idx
    task automatic shift_out(input int unsigned idx);
        for (int unsigned k = idx; k + 1 < list_len; k++)
            list_cells[k] = list_cells[k+1];
        list_len--;
    endtask

    // apply one request to the predicted list and queue its results
    task automatic predict_list_request(input logic [bole_pkg::CMD_W-1:0] c,
                                        input logic signed [bole_pkg::DATA_W-1:0] v,
                                        input logic [bole_pkg::POS_W-1:0] p);
        logic [bole_pkg::STAT_W-1:0]        st;
        logic                               hit;
        logic signed [bole_pkg::DATA_W-1:0] lo;
        logic signed [bole_pkg::DATA_W-1:0] hi;
        st  = bole_pkg::STAT_OK;
        hit = 1'b0;
        lo  = '0;
        hi  = '0;
        // dump streams one result per element
        if (c == bole_pkg::CMD_DUMP)
        begin
            if (list_len == 0)
                push_result(bole_pkg::STAT_EMPTY, 1'b0, '0, '0, '0, 1'b1);
            else
                for (int unsigned k = 0; k < list_len; k++)
                    push_result(bole_pkg::STAT_OK, 1'b0, list_cells[k], '0, '0,
                                k + 1 == list_len);
            return;
        end
        case (c)
            bole_pkg::CMD_APPEND:
                if (list_len >= DEPTH) st = bole_pkg::STAT_FULL;
                else shift_in(list_len, v);
            bole_pkg::CMD_INS_HEAD:
                if (list_len >= DEPTH) st = bole_pkg::STAT_FULL;
                else shift_in(0, v);
            bole_pkg::CMD_INS_AT:
                if (list_len >= DEPTH) st = bole_pkg::STAT_FULL;
                else if (p == 1) shift_in(0, v);
                else if (p == 0 || p > list_len) st = bole_pkg::STAT_RANGE;
                else shift_in(p - 1, v);
            bole_pkg::CMD_DEL_TAIL:
                if (list_len == 0) st = bole_pkg::STAT_EMPTY;
                else shift_out(list_len - 1);
            bole_pkg::CMD_DEL_HEAD:
                if (list_len == 0) st = bole_pkg::STAT_EMPTY;
                else shift_out(0);
            bole_pkg::CMD_DEL_AT:
                if (list_len == 0) st = bole_pkg::STAT_EMPTY;
                else if (p == 0 || p > list_len) st = bole_pkg::STAT_RANGE;
                else shift_out(p - 1);
            bole_pkg::CMD_SEARCH:
                if (list_len == 0) st = bole_pkg::STAT_EMPTY;
                else
                    for (int unsigned k = 0; k < list_len; k++)
                        if (list_cells[k] == v) hit = 1'b1;
            bole_pkg::CMD_STATS:
                if (list_len == 0) st = bole_pkg::STAT_EMPTY;
                else
                begin
                    lo = list_cells[0];
                    hi = list_cells[0];
                    for (int unsigned k = 1; k < list_len; k++)
                    begin
                        if (list_cells[k] < lo) lo = list_cells[k];
                        if (list_cells[k] > hi) hi = list_cells[k];
                    end
                end
            default:
                st = bole_pkg::STAT_OK;
        endcase
        push_result(st, hit, '0, lo, hi, 1'b1);
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // check results first, then take the new request
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t w;
        if (!rst_n)
        begin
            awaited_results.delete();
            list_len   = 0;
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with none outstanding: status %0d element %0d",
                           status, element);
                    fail_count++;
                end
                else
                begin
                    w = awaited_results.pop_front();
                    compare_field("status", w.status, status);
                    compare_field("found", w.found, found);
                    compare_field("element", $signed(w.element), element);
                    compare_field("count", w.count, count);
                    compare_field("minimum", $signed(w.minimum), minimum);
                    compare_field("maximum", $signed(w.maximum), maximum);
                    compare_field("last", w.last, last);
                end
            end
            if (req_valid && !req_stall)
                predict_list_request(cmd, value, position);
            pending = awaited_results.size();
        end
    end

endmodule

@@ tb/sv/bounded_ordered_list_engine_tb.sv @@
`timescale 1ns / 100ps

module bounded_ordered_list_engine_tb;

    localparam int unsigned               LIST_DEPTH      = bole_pkg::DEPTH_DEFAULT;
    localparam logic [bole_pkg::CMD_W-1:0] CMD_SPARE_LO   = 4'd9;
    localparam logic [bole_pkg::CMD_W-1:0] CMD_SPARE_HI   = 4'd15;
    localparam int                        HOLD_CYCLES     = 80;
    localparam int                        DRAIN_CYCLES    = 20;
    localparam int                        RANDOM_REQUESTS = 380;
    localparam int                        PHASE_LEN       = 60;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               req_valid;
    logic                               req_stall;
    logic [bole_pkg::CMD_W-1:0]         cmd;
    logic signed [bole_pkg::DATA_W-1:0] value;
    logic [bole_pkg::POS_W-1:0]         position;
    logic                               rsp_valid;
    logic                               rsp_stall;
    logic [bole_pkg::STAT_W-1:0]        status;
    logic                               found;
    logic signed [bole_pkg::DATA_W-1:0] element;
    logic [bole_pkg::COUNT_W-1:0]       count;
    logic signed [bole_pkg::DATA_W-1:0] minimum;
    logic signed [bole_pkg::DATA_W-1:0] maximum;
    logic                               last;
    int                                 fail_count;
    int                                 pending;

    logic send_idle_on;
    logic recv_idle_on;
    logic hold_off_req;
    logic hold_off_done;

    bounded_ordered_list_engine #(.DEPTH(LIST_DEPTH)) DUT (.*);

    bole_list_checker #(.DEPTH(LIST_DEPTH)) list_checker (.*);

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL bounded_ordered_list_engine");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        rsp_stall     = 1'b0;
        hold_off_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                rsp_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_done = 1'b1;
            end
            rsp_stall = recv_idle_on && ($urandom_range(99) < 33);
        end
    end

    // mostly small values so searches hit, plus extremes and full range
    function automatic logic signed [bole_pkg::DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 5)
            return bole_pkg::DATA_W'(int'($urandom_range(16)) - 8);
        else if (r == 5)
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return '0;
                default: return '1;
            endcase
        return $urandom();
    endfunction

    function automatic logic [bole_pkg::POS_W-1:0] pick_position();
        if ($urandom_range(99) < 85)
            return bole_pkg::POS_W'($urandom_range(LIST_DEPTH + 1));
        return bole_pkg::POS_W'($urandom_range(255));
    endfunction

    // weighted command mix, biased to fill or to drain the list
    function automatic logic [bole_pkg::CMD_W-1:0] pick_command(input logic grow);
        int unsigned r;
        r = $urandom_range(99);
        if (grow)
        begin
            if (r < 25) return bole_pkg::CMD_APPEND;
            if (r < 40) return bole_pkg::CMD_INS_HEAD;
            if (r < 55) return bole_pkg::CMD_INS_AT;
            if (r < 62) return bole_pkg::CMD_DEL_TAIL;
            if (r < 69) return bole_pkg::CMD_DEL_HEAD;
            if (r < 76) return bole_pkg::CMD_DEL_AT;
            if (r < 85) return bole_pkg::CMD_SEARCH;
            if (r < 91) return bole_pkg::CMD_STATS;
            if (r < 97) return bole_pkg::CMD_DUMP;
        end
        else
        begin
            if (r < 8)  return bole_pkg::CMD_APPEND;
            if (r < 13) return bole_pkg::CMD_INS_HEAD;
            if (r < 18) return bole_pkg::CMD_INS_AT;
            if (r < 33) return bole_pkg::CMD_DEL_TAIL;
            if (r < 48) return bole_pkg::CMD_DEL_HEAD;
            if (r < 66) return bole_pkg::CMD_DEL_AT;
            if (r < 78) return bole_pkg::CMD_SEARCH;
            if (r < 86) return bole_pkg::CMD_STATS;
            if (r < 96) return bole_pkg::CMD_DUMP;
        end
        return bole_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    endfunction

    // offer one request from a falling edge and hold it until taken
    task automatic send_request(input logic [bole_pkg::CMD_W-1:0] c,
                                input logic signed [bole_pkg::DATA_W-1:0] v,
                                input logic [bole_pkg::POS_W-1:0] p);
        while (send_idle_on && $urandom_range(99) < 33)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        cmd       = c;
        value     = v;
        position  = p;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        @(negedge clk);
    endtask

    // stop offering and let every outstanding result come out
    task automatic wait_drained();
        req_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // request stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        cmd          = bole_pkg::CMD_APPEND;
        value        = '0;
        position     = '0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        hold_off_req = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty list errors
        send_request(bole_pkg::CMD_DEL_TAIL, 0, 0);
        send_request(bole_pkg::CMD_DEL_HEAD, 0, 0);
        send_request(bole_pkg::CMD_DEL_AT, 0, 1);
        send_request(bole_pkg::CMD_SEARCH, 0, 0);
        send_request(bole_pkg::CMD_STATS, 0, 0);
        send_request(bole_pkg::CMD_DUMP, 0, 0);
        send_request(bole_pkg::CMD_INS_AT, 3, 0);
        send_request(bole_pkg::CMD_INS_AT, 5, 2);
        // insert at 1 on an empty list, then extremes
        send_request(bole_pkg::CMD_INS_AT, 7, 1);
        send_request(bole_pkg::CMD_APPEND, 32'sh7FFF_FFFF, 0);
        send_request(bole_pkg::CMD_INS_HEAD, 32'sh8000_0000, 0);
        // insert at position equal to count
        send_request(bole_pkg::CMD_INS_AT, -1, 3);
        send_request(bole_pkg::CMD_INS_AT, 9, 5);
        send_request(bole_pkg::CMD_SEARCH, -1, 0);
        send_request(bole_pkg::CMD_SEARCH, 0, 0);
        send_request(bole_pkg::CMD_STATS, 0, 0);
        send_request(bole_pkg::CMD_DUMP, 0, 0);
        send_request(bole_pkg::CMD_DEL_AT, 0, 0);
        send_request(bole_pkg::CMD_DEL_AT, 0, 255);
        send_request(bole_pkg::CMD_DEL_AT, 0, 2);
        send_request(CMD_SPARE_HI, -1, 255);
        send_request(CMD_SPARE_LO, 0, 0);
        send_request(bole_pkg::CMD_DEL_TAIL, 0, 0);
        send_request(bole_pkg::CMD_DEL_HEAD, 0, 0);
        // deleting the only element empties the list
        send_request(bole_pkg::CMD_DEL_AT, 0, 1);
        send_request(bole_pkg::CMD_DUMP, 0, 0);

        // receiver holds off while the list fills past full
        send_idle_on = 1'b0;
        hold_off_req = 1'b1;
        for (int i = 0; i < LIST_DEPTH + 4; i++)
            send_request(bole_pkg::CMD_APPEND, pick_value(), 0);
        send_request(bole_pkg::CMD_INS_HEAD, pick_value(), 0);
        send_request(bole_pkg::CMD_INS_AT, pick_value(), 4);
        send_request(bole_pkg::CMD_DUMP, 0, 0);
        send_request(bole_pkg::CMD_STATS, 0, 0);
        send_idle_on = 1'b1;
        wait_drained();

        // random traffic, alternating fill and drain phases
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 150)
            begin
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
            end
            if (i == 230)
            begin
                send_idle_on = 1'b1;
                recv_idle_on = 1'b1;
            end
            send_request(pick_command((i / PHASE_LEN) % 2 == 0), pick_value(),
                         pick_position());
        end

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("PASS bounded_ordered_list_engine");
        else
            $display("FAIL bounded_ordered_list_engine");
        $finish;
    end

endmodule
